FILE: rtl/isort_pkg.sv
// Shared constants and types for the insertion sorter cell chain.
package isort_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_WIDTH = 32;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic    insert;
      logic    drain;
      key_type key;
   } cell_ctl_type;

endpackage

FILE: rtl/isort_cell.sv
// One storage cell of the sorting chain: keeps one key, shifts up on insert, down on drain.
module isort_cell
   import isort_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         prev_gt,
   input  logic         prev_valid,
   input  key_type      prev_key,
   input  logic         next_valid,
   input  key_type      next_key,
   output logic         gt,
   output logic         valid,
   output key_type      key
);

   logic    valid_ff;
   logic    valid_in;
   key_type key_ff;
   key_type key_in;

   assign gt    = valid_ff && (key_ff > ctl.key);
   assign valid = valid_ff;
   assign key   = key_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (ctl.drain) begin
         valid_in = next_valid;
         key_in   = next_key;
      end else if (ctl.insert) begin
         if (prev_gt) begin
            valid_in = 1'b1;
            key_in   = prev_key;
         end else if (gt || (!valid_ff && prev_valid)) begin
            valid_in = 1'b1;
            key_in   = ctl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

FILE: rtl/isort_ctrl.sv
// Sequencer for the sorter: fill phase, drain phase and the overflow flag.
module isort_ctrl
   import isort_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_last,
   input  key_type      req_value,
   input  logic         full,
   input  logic         head_valid,
   input  logic         second_valid,
   output cell_ctl_type ctl,
   output logic         busy,
   output logic         rsp_strobe,
   output logic         rsp_last_res,
   output logic         rsp_overflow
);

   state_type state_ff;
   state_type state_in;
   logic      overflow_ff;
   logic      overflow_in;
   logic      accept;

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      busy        = 1'b0;
      accept      = 1'b0;
      ctl.insert  = 1'b0;
      ctl.drain   = 1'b0;
      ctl.key     = req_value;
      case (state_ff)
         ST_FILL: begin
            accept = start;
            if (accept) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  ctl.insert = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            busy      = 1'b1;
            ctl.drain = 1'b1;
            if (!second_valid) begin
               state_in    = ST_FILL;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   assign rsp_strobe   = (state_ff == ST_DRAIN) && head_valid;
   assign rsp_last_res = !second_valid;
   assign rsp_overflow = overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_FILL;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

FILE: rtl/insertion_sorter.sv
// Stable insertion sorter: a chain of compare-and-shift cells with a fill/drain sequencer.
// Fill: one key accepted per cycle; all cells compare with the new key at once.
// Drain: first result in the cycle after the transfer marked last, then one per cycle
//   for the n keys held; start is ignored while busy.
// Results cannot be held off by the receiver. Synchronous reset empties the chain.
module insertion_sorter
   import isort_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  key_type req_value,
   input  logic    req_last,
   output logic    rsp_strobe,
   output key_type rsp_value_res,
   output logic    rsp_last_res,
   output logic    rsp_overflow
);

   cell_ctl_type ctl;
   logic         gt_w    [CAPACITY];
   logic         valid_w [CAPACITY];
   key_type      key_w   [CAPACITY];

   isort_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_last     (req_last),
      .req_value    (req_value),
      .full         (valid_w[CAPACITY-1]),
      .head_valid   (valid_w[0]),
      .second_valid (valid_w[1]),
      .ctl          (ctl),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_last_res (rsp_last_res),
      .rsp_overflow (rsp_overflow)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic    prev_gt;
      logic    prev_valid;
      key_type prev_key;
      logic    next_valid;
      key_type next_key;

      if (i == 0) begin : g_head
         assign prev_gt    = 1'b0;
         assign prev_valid = 1'b1;
         assign prev_key   = '0;
      end else begin : g_body
         assign prev_gt    = gt_w[i-1];
         assign prev_valid = valid_w[i-1];
         assign prev_key   = key_w[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_key   = '0;
      end else begin : g_inner
         assign next_valid = valid_w[i+1];
         assign next_key   = key_w[i+1];
      end

      isort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_gt    (prev_gt),
         .prev_valid (prev_valid),
         .prev_key   (prev_key),
         .next_valid (next_valid),
         .next_key   (next_key),
         .gt         (gt_w[i]),
         .valid      (valid_w[i]),
         .key        (key_w[i])
      );
   end

   assign rsp_value_res = key_w[0];

endmodule

FILE: rtl/isort_checker.sv
// Port-level checks for the insertion sorter, bound to the top level.
module isort_checker
   import isort_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    req_last,
   input logic    rsp_strobe,
   input key_type rsp_value_res,
   input logic    rsp_last_res,
   input logic    rsp_overflow
);

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result outside drain");

   a_end_of_list: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_res |=> !busy)
      else $error("busy after final result");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_res |=> rsp_strobe)
      else $error("gap in result list");

   a_drain_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last |=> busy && rsp_strobe)
      else $error("list end not followed by results");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_res |=>
         rsp_overflow == $past(rsp_overflow) && rsp_value_res >= $past(rsp_value_res))
      else $error("results out of order or overflow changed");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_last      (req_last),
   .rsp_strobe    (rsp_strobe),
   .rsp_value_res (rsp_value_res),
   .rsp_last_res  (rsp_last_res),
   .rsp_overflow  (rsp_overflow)
);

FILE: sim/testbench.sv
// Self-checking testbench for the stable insertion sorter, with an in-bench sort predictor.
module testbench;
   import isort_pkg::*;

   localparam int SILENT_LIMIT = 1000;

   typedef struct {
      key_type value;
      logic    is_final;
      logic    overflow;
   } sorted_entry_type;

   class sort_scoreboard;
      key_type          held_keys[$];
      bit               keys_dropped;
      sorted_entry_type sorted_out[$];
      int               failures;
      int               lists_done;
      int               overflow_lists;
      int               results_seen;

      // stable insert: only strictly greater keys move up
      function void note_transfer(key_type value, logic is_last);
         int               pos;
         sorted_entry_type entry;
         if (held_keys.size() >= CAPACITY) begin
            keys_dropped = 1'b1;
         end else begin
            pos = held_keys.size();
            while (pos > 0 && held_keys[pos-1] > value)
               pos--;
            held_keys.insert(pos, value);
         end
         if (is_last) begin
            foreach (held_keys[k]) begin
               entry.value    = held_keys[k];
               entry.is_final = (k == held_keys.size() - 1);
               entry.overflow = keys_dropped;
               sorted_out.push_back(entry);
            end
            lists_done++;
            if (keys_dropped)
               overflow_lists++;
            held_keys.delete();
            keys_dropped = 1'b0;
         end
      endfunction

      function void check_result(key_type value, logic is_final, logic overflow);
         sorted_entry_type entry;
         results_seen++;
         if (sorted_out.size() == 0) begin
            $display("%0t: unexpected result value %0d last %b overflow %b",
                     $time, value, is_final, overflow);
            failures++;
            return;
         end
         entry = sorted_out.pop_front();
         if (value !== entry.value) begin
            $display("%0t: value expected %0d actual %0d", $time, entry.value, value);
            failures++;
         end
         if (is_final !== entry.is_final) begin
            $display("%0t: last flag expected %b actual %b", $time, entry.is_final, is_final);
            failures++;
         end
         if (overflow !== entry.overflow) begin
            $display("%0t: overflow expected %b actual %b", $time, entry.overflow, overflow);
            failures++;
         end
      endfunction

      function int pending();
         return sorted_out.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   key_type req_value = '0;
   logic    req_last = 1'b0;
   logic    rsp_strobe;
   key_type rsp_value_res;
   logic    rsp_last_res;
   logic    rsp_overflow;

   sort_scoreboard sb = new();
   int keys_sent;
   int silent_cycles;

   insertion_sorter u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_overflow  (rsp_overflow)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // transfers, results and the watchdog, all on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_result(rsp_value_res, rsp_last_res, rsp_overflow);
         if (start && !busy)
            sb.note_transfer(req_value, req_last);
         if (rsp_strobe || (start && !busy))
            silent_cycles = 0;
         else
            silent_cycles++;
         if (silent_cycles >= SILENT_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   function automatic key_type random_key();
      key_type pick;
      case ($urandom_range(3))
         0: pick = $signed($urandom_range(8)) - 4;
         1: case ($urandom_range(3))
               0: pick = 32'sh8000_0000;
               1: pick = 32'sh7fff_ffff;
               2: pick = '0;
               default: pick = '1;
            endcase
         default: pick = $urandom;
      endcase
      return pick;
   endfunction

   // called at a rising edge; returns at the edge where the transfer happens
   task automatic send_key(key_type value, logic is_last, int idle_pct);
      int gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 12)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      req_last  <= is_last;
      do @(posedge clock); while (busy);
      keys_sent++;
   endtask

   task automatic send_list(int length, int idle_pct);
      for (int i = 0; i < length; i++)
         send_key(random_key(), i == length - 1, idle_pct);
   endtask

   initial begin
      int idle_pct;
      int phase_keys;
      key_type directed_keys[$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single-key lists at the extremes
      send_key(32'sh7fff_ffff, 1'b1, 0);
      send_key(32'sh8000_0000, 1'b1, 0);
      // extremes and duplicates mixed
      directed_keys = '{0, -1, 32'sh7fff_ffff, 32'sh8000_0000, 1, -1, 0};
      foreach (directed_keys[i])
         send_key(directed_keys[i], i == directed_keys.size() - 1, 0);
      // descending: every stored key shifts
      for (int i = 5; i >= 1; i--)
         send_key(i, i == 1, 0);
      // equal keys
      for (int i = 0; i < 3; i++)
         send_key(7, i == 2, 0);
      send_key(-2, 1'b0, 0);
      send_key(32'sh5555_aaaa, 1'b0, 0);
      send_key(32'shaaaa_5555, 1'b1, 0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       idle_pct = 59;
            3:       idle_pct = 22;
            default: idle_pct = 0;
         endcase
         // fills the store and drops the surplus
         if (phase == 1)
            send_list(CAPACITY + $urandom_range(1, 4), idle_pct);
         phase_keys = keys_sent;
         while (keys_sent - phase_keys < 4) begin
            if ($urandom_range(9) == 0)
               send_list($urandom_range(9, 24), idle_pct);
            else
               send_list($urandom_range(1, 8), idle_pct);
         end
      end
      start <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d key transfers in %0d lists (%0d with dropped keys), %0d results",
               keys_sent, sb.lists_done, sb.overflow_lists, sb.results_seen);
      if (sb.failures == 0 && sb.held_keys.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
